### src/crtu_pkg.sv
// ----------------------------------------------------------------------------
// crtu_pkg
// Shared types and constants for the CMOS clock snapshot to Unix seconds
// pipeline: stage payload structs, status B bits and the month offset table.
// ----------------------------------------------------------------------------
package crtu_pkg;

  // status B bits
  localparam int unsigned SB_BINARY_BIT = 2;
  localparam int unsigned SB_24H_BIT    = 1;

  // hour register PM flag
  localparam int unsigned HOUR_PM_BIT   = 7;

  // Field limits
  localparam logic [7:0] MAX_SEC   = 8'd60;
  localparam logic [7:0] MAX_MIN   = 8'd59;
  localparam logic [6:0] MAX_HOUR  = 7'd23;
  localparam logic [7:0] MAX_DAY   = 8'd31;
  localparam logic [7:0] MAX_MONTH = 8'd12;
  localparam logic [6:0] NOON_HOUR = 7'd12;

  // Century window and fallback year
  localparam logic [7:0] CENT_LO       = 8'd19;
  localparam logic [7:0] CENT_HI       = 8'd21;
  localparam logic [7:0] YEAR_PIVOT    = 8'd70;
  localparam logic [7:0] FALLBACK_YEAR = 8'd70;

  // Years are counted from 1600 (a multiple of 400) inside the pipeline.
  localparam logic [11:0] YEAR_BASE  = 12'd1600;
  // Day number of the epoch in the 1600-based count: 719468 - 365*1600 - 388.
  localparam logic [19:0] EPOCH_DAYS = 20'd135080;
  localparam logic [33:0] SEC_PER_DAY = 34'd86400;

  // Decoded and range-checked fields
  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] mon;
    logic [7:0] year;
    logic [7:0] cent;
    logic       bad;
  } crtu_fields_t;

  // Shifted year, day of the March-based year and time of day
  typedef struct packed {
    logic [9:0]  yr;
    logic [8:0]  doy;
    logic [16:0] tod;
    logic        bad;
  } crtu_cal_t;

  // Days since epoch, clamped at zero, and time of day
  typedef struct packed {
    logic [17:0] days;
    logic [16:0] tod;
    logic        bad;
  } crtu_days_t;

  // Days before the first of each month of a year that starts in March.
  function automatic logic [8:0] month_offset(input logic [3:0] mp);
    logic [8:0] off;
    case (mp)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  // Packed BCD byte to binary, nibbles taken as they are.
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
    return 8'(v[3:0]) + {1'b0, v[7:4], 3'b000} + {3'b000, v[7:4], 1'b0};
  endfunction

endpackage

### src/crtu_decode.sv
// ----------------------------------------------------------------------------
// crtu_decode
// Stage 1: BCD decode, 12/24-hour conversion, range check and epoch fallback.
// ----------------------------------------------------------------------------
module crtu_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [7:0]            sec_raw,
  input  logic [7:0]            min_raw,
  input  logic [7:0]            hour_raw,
  input  logic [7:0]            day_raw,
  input  logic [7:0]            month_raw,
  input  logic [7:0]            year_raw,
  input  logic [7:0]            century_raw,
  input  logic [7:0]            status_b,
  output logic                  valid_o,
  input  logic                  ready_i,
  output crtu_pkg::crtu_fields_t data_o
);

  logic                   valid_r;
  crtu_pkg::crtu_fields_t data_r;
  crtu_pkg::crtu_fields_t data_nxt;

  logic       binary;
  logic       h24;
  logic       pm;
  logic [7:0] sec_d;
  logic [7:0] min_d;
  logic [7:0] day_d;
  logic [7:0] mon_d;
  logic [7:0] year_d;
  logic [7:0] cent_d;
  logic [6:0] hour_d;
  logic [6:0] hour_c;
  logic       bad12;
  logic       bad;

  always_comb begin
    binary = status_b[crtu_pkg::SB_BINARY_BIT];
    h24    = status_b[crtu_pkg::SB_24H_BIT];
    pm     = hour_raw[crtu_pkg::HOUR_PM_BIT];

    if (!binary) begin
      sec_d  = crtu_pkg::bcd_to_bin(sec_raw);
      min_d  = crtu_pkg::bcd_to_bin(min_raw);
      day_d  = crtu_pkg::bcd_to_bin(day_raw);
      mon_d  = crtu_pkg::bcd_to_bin(month_raw);
      year_d = crtu_pkg::bcd_to_bin(year_raw);
      cent_d = crtu_pkg::bcd_to_bin(century_raw);
      // tens digit of the hour is bits 6..4 only
      hour_d = 7'(hour_raw[3:0]) + {1'b0, hour_raw[6:4], 3'b000} + {3'b000, hour_raw[6:4], 1'b0};
    end else begin
      sec_d  = sec_raw;
      min_d  = min_raw;
      day_d  = day_raw;
      mon_d  = month_raw;
      year_d = year_raw;
      cent_d = century_raw;
      hour_d = hour_raw[6:0];
    end

    bad12  = 1'b0;
    hour_c = hour_d;
    if (!h24) begin
      if (hour_d == 7'd0 || hour_d > crtu_pkg::NOON_HOUR) begin
        bad12 = 1'b1;
      end else begin
        // 12 AM maps to 0, 12 PM stays 12
        hour_c = ((hour_d == crtu_pkg::NOON_HOUR) ? 7'd0 : hour_d)
               + (pm ? crtu_pkg::NOON_HOUR : 7'd0);
      end
    end

    bad = bad12 || mon_d == 8'd0 || mon_d > crtu_pkg::MAX_MONTH ||
          day_d == 8'd0 || day_d > crtu_pkg::MAX_DAY ||
          hour_c > crtu_pkg::MAX_HOUR || min_d > crtu_pkg::MAX_MIN ||
          sec_d > crtu_pkg::MAX_SEC;

    if (bad) begin
      data_nxt.sec  = 6'd0;
      data_nxt.min  = 6'd0;
      data_nxt.hour = 5'd0;
      data_nxt.day  = 5'd1;
      data_nxt.mon  = 4'd1;
      data_nxt.year = crtu_pkg::FALLBACK_YEAR;
      data_nxt.cent = 8'd0;
    end else begin
      data_nxt.sec  = sec_d[5:0];
      data_nxt.min  = min_d[5:0];
      data_nxt.hour = hour_c[4:0];
      data_nxt.day  = day_d[4:0];
      data_nxt.mon  = mon_d[3:0];
      data_nxt.year = year_d;
      data_nxt.cent = cent_d;
    end
    data_nxt.bad = bad;
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

### src/crtu_calendar.sv
// ----------------------------------------------------------------------------
// crtu_calendar
// Stage 2: full year, March-based year and day of year, and time of day.
// ----------------------------------------------------------------------------
module crtu_calendar (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  crtu_pkg::crtu_fields_t data_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output crtu_pkg::crtu_cal_t    data_o
);

  logic                 valid_r;
  crtu_pkg::crtu_cal_t  data_r;
  crtu_pkg::crtu_cal_t  data_nxt;

  logic [11:0] full_year;
  logic [11:0] yr_wide;
  logic        early;
  logic [3:0]  mp;

  always_comb begin
    if (data_i.cent >= crtu_pkg::CENT_LO && data_i.cent <= crtu_pkg::CENT_HI) begin
      case (data_i.cent)
        crtu_pkg::CENT_LO: full_year = 12'd1900 + 12'(data_i.year);
        crtu_pkg::CENT_HI: full_year = 12'd2100 + 12'(data_i.year);
        default:           full_year = 12'd2000 + 12'(data_i.year);
      endcase
    end else if (data_i.year < crtu_pkg::YEAR_PIVOT) begin
      full_year = 12'd2000 + 12'(data_i.year);
    end else begin
      full_year = 12'd1900 + 12'(data_i.year);
    end

    // January and February count with the previous year
    early   = (data_i.mon <= 4'd2);
    yr_wide = full_year - crtu_pkg::YEAR_BASE - 12'(early);
    mp      = early ? (data_i.mon + 4'd9) : (data_i.mon - 4'd3);

    data_nxt.yr  = yr_wide[9:0];
    data_nxt.doy = crtu_pkg::month_offset(mp) + 9'(data_i.day) - 9'd1;
    data_nxt.tod = 17'(data_i.hour) * 17'd3600 + 17'(data_i.min) * 17'd60
                 + 17'(data_i.sec);
    data_nxt.bad = data_i.bad;
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

### src/crtu_daycount.sv
// ----------------------------------------------------------------------------
// crtu_daycount
// Stage 3: Gregorian day count since the epoch, clamped at zero.
// ----------------------------------------------------------------------------
module crtu_daycount (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  output logic                ready_o,
  input  crtu_pkg::crtu_cal_t data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output crtu_pkg::crtu_days_t data_o
);

  logic                 valid_r;
  crtu_pkg::crtu_days_t data_r;
  crtu_pkg::crtu_days_t data_nxt;

  logic [14:0] yr_x41;
  logic [2:0]  cent_cnt;
  logic        ge400;
  logic [19:0] day_sum;
  logic [19:0] day_rel;

  always_comb begin
    // yr / 100 via 41/4096, exact for yr below 800
    yr_x41   = 15'(data_i.yr) * 15'd41;
    cent_cnt = yr_x41[14:12];
    ge400    = (data_i.yr >= 10'd400);
    day_sum  = 20'(data_i.yr) * 20'd365 + 20'(data_i.yr[9:2]) + 20'(ge400)
             + 20'(data_i.doy) - 20'(cent_cnt);
    day_rel  = day_sum - crtu_pkg::EPOCH_DAYS;

    // before the epoch the result saturates to zero
    if (day_sum < crtu_pkg::EPOCH_DAYS) begin
      data_nxt.days = 18'd0;
      data_nxt.tod  = 17'd0;
    end else begin
      data_nxt.days = day_rel[17:0];
      data_nxt.tod  = data_i.tod;
    end
    data_nxt.bad = data_i.bad;
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

### src/crtu_scale.sv
// ----------------------------------------------------------------------------
// crtu_scale
// Stage 4: days times 86400 plus time of day into the output register.
// ----------------------------------------------------------------------------
module crtu_scale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  crtu_pkg::crtu_days_t data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [33:0]          unix_seconds,
  output logic                 fell_back
);

  logic        valid_r;
  logic [33:0] secs_r;
  logic [33:0] secs_nxt;
  logic        bad_r;

  assign secs_nxt = 34'(data_i.days) * crtu_pkg::SEC_PER_DAY + 34'(data_i.tod);
  assign ready_o  = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      secs_r <= secs_nxt;
      bad_r  <= data_i.bad;
    end
  end

  assign valid_o      = valid_r;
  assign unix_seconds = secs_r;
  assign fell_back    = bad_r;

endmodule

### src/cmos_rtc_to_unix_seconds.sv
// ----------------------------------------------------------------------------
// cmos_rtc_to_unix_seconds
// Converts one snapshot of CMOS clock registers into Unix seconds.
// ----------------------------------------------------------------------------
// Four-stage register pipeline: decode and range check, calendar fields, day
// count, then the multiply by 86400 into the output register. One snapshot
// can be taken every cycle while out_ready stays high. Every stage holds its own
// valid bit and accepts new data when empty or when the stage below moves,
// so a stalled output still lets bubbles in the pipeline fill. Out-of-range
// fields give 0 with out_fell_back set; dates before 1970 give 0 without it.
module cmos_rtc_to_unix_seconds (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_sec_raw,
  input  logic [7:0]  in_min_raw,
  input  logic [7:0]  in_hour_raw,
  input  logic [7:0]  in_day_raw,
  input  logic [7:0]  in_month_raw,
  input  logic [7:0]  in_year_raw,
  input  logic [7:0]  in_century_raw,
  input  logic [7:0]  in_status_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [33:0] out_unix_seconds,
  output logic        out_fell_back
);

  logic                   s1_valid;
  logic                   s1_ready;
  crtu_pkg::crtu_fields_t s1_data;
  logic                   s2_valid;
  logic                   s2_ready;
  crtu_pkg::crtu_cal_t    s2_data;
  logic                   s3_valid;
  logic                   s3_ready;
  crtu_pkg::crtu_days_t   s3_data;

  crtu_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_i     (in_valid),
    .ready_o     (in_ready),
    .sec_raw     (in_sec_raw),
    .min_raw     (in_min_raw),
    .hour_raw    (in_hour_raw),
    .day_raw     (in_day_raw),
    .month_raw   (in_month_raw),
    .year_raw    (in_year_raw),
    .century_raw (in_century_raw),
    .status_b    (in_status_b),
    .valid_o     (s1_valid),
    .ready_i     (s1_ready),
    .data_o      (s1_data)
  );

  crtu_calendar u_calendar (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  crtu_daycount u_daycount (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .data_o  (s3_data)
  );

  crtu_scale u_scale (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid_i      (s3_valid),
    .ready_o      (s3_ready),
    .data_i       (s3_data),
    .valid_o      (out_valid),
    .ready_i      (out_ready),
    .unix_seconds (out_unix_seconds),
    .fell_back    (out_fell_back)
  );

endmodule

### src/crtu_checker.sv
// ----------------------------------------------------------------------------
// crtu_checker
// Port-level checks for the RTC snapshot to Unix seconds pipeline.
// ----------------------------------------------------------------------------
module crtu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [33:0] out_unix_seconds,
  input logic        out_fell_back
);

  // Output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A free output means every stage above can move.
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ready || !out_valid) |-> in_ready)
    else $error("in_ready low while output can drain");

  // Fallback always yields the epoch.
  a_fallback_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fell_back) |-> (out_unix_seconds == 34'd0))
    else $error("fallback result is not zero");

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_unix_seconds) && $stable(out_fell_back)))
    else $error("stalled result changed");

endmodule

bind cmos_rtc_to_unix_seconds crtu_checker u_crtu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_unix_seconds (out_unix_seconds),
  .out_fell_back    (out_fell_back)
);
